@@ rtl/stc_pkg.sv @@
`default_nettype none

package stc_pkg;

    localparam int ADC_W           = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MV_SCALE        = 3300;
    localparam int MV_W            = 12;
    localparam int W_W             = ADC_W + MV_W;
    localparam int LO_W            = 24;
    localparam int TEMP_W          = 19;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 19;
    localparam int STATUS_W        = 2;
    localparam int PIPE_DEPTH      = 12;

    localparam int COEF_A_W = 38;
    localparam int T1_W     = 44;
    localparam int T2_W     = 42;
    localparam int T3_W     = 54;
    localparam int T_W      = T3_W - 31;

    localparam int SH_A = 40;
    localparam int SH_B = 48;
    localparam int SH_C = 32;

    localparam logic signed [COEF_A_W-1:0] COEF_A_Q56 = -38'sd76683691575;
    localparam logic signed [T1_W-1:0]     COEF_B_Q48 = -44'sd1621218460235;
    localparam logic signed [T2_W-1:0]     COEF_C_Q32 = -42'sd768748894867;
    localparam logic signed [T3_W-1:0]     COEF_D_Q32 = 54'sd879854115356672;

    localparam int COLD_MDEG = -55000;
    localparam int HOT_MDEG  = 150000;

    localparam logic [ADC_W-1:0]         COLD_END_RST = 16'd27310;
    localparam logic [ADC_W-1:0]         HOT_END_RST  = 16'd6013;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST = 19'sd150000;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST = -19'sd55000;

    typedef enum logic [STATUS_W-1:0] {
        ST_IN_RANGE = 2'd0,
        ST_COLD_END = 2'd1,
        ST_HOT_END  = 2'd2,
        ST_CLAMPED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLD_END = 2'd0,
        CFG_HOT_END  = 2'd1,
        CFG_TEMP_MAX = 2'd2,
        CFG_TEMP_MIN = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic adv;
        logic skid_load;
        logic skid_sel;
    } ctl_t;

endpackage

`default_nettype wire

@@ rtl/stc_ctrl.sv @@
`default_nettype none

module stc_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output stc_pkg::ctl_t     ctl
);

    localparam int D = stc_pkg::PIPE_DEPTH;

    logic [D-1:0] v_reg;
    logic [D-1:0] v_next;
    logic         skid_v_reg;
    logic         skid_v_next;
    logic         adv;

    assign adv       = !skid_v_reg;
    assign in_ready  = adv;
    assign out_valid = skid_v_reg | v_reg[D-1];

    assign ctl.adv       = adv;
    assign ctl.skid_load = adv & v_reg[D-1] & !out_ready;
    assign ctl.skid_sel  = skid_v_reg;

    always_comb
    begin
        v_next = v_reg;
        if (adv)
        begin
            v_next = {v_reg[D-2:0], in_valid};
        end
        if (skid_v_reg)
        begin
            skid_v_next = !out_ready;
        end
        else
        begin
            skid_v_next = v_reg[D-1] & !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            v_reg      <= v_next;
            skid_v_reg <= skid_v_next;
        end
    end

`ifndef SYNTH
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(v_reg[D-1] && !out_ready))
        else $error("skid filled without a stalled word");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |=> $stable(v_reg))
        else $error("pipeline moved while skid full");

    a_skid_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !out_ready) |=> skid_v_reg)
        else $error("skid word dropped");
`endif

endmodule

`default_nettype wire

@@ rtl/stc_mulrnd.sv @@
`default_nettype none

module stc_mulrnd #(
    parameter int                       IN_W   = 38,
    parameter int                       OUT_W  = 44,
    parameter int                       SHIFT  = 24,
    parameter int                       SIDE_W = 2,
    parameter logic signed [OUT_W-1:0]  ADDEND = '0
) (
    input  wire logic                          clk,
    input  wire logic                          adv,
    input  wire logic signed [IN_W-1:0]        mult,
    input  wire logic [stc_pkg::W_W-1:0]       w,
    input  wire logic [SIDE_W-1:0]             side,
    output logic signed [OUT_W-1:0]            result,
    output logic [SIDE_W-1:0]                  side_out
);

    localparam int LO_W  = stc_pkg::LO_W;
    localparam int HI_W  = IN_W - LO_W;
    localparam int W_W   = stc_pkg::W_W;
    localparam int PL_W  = LO_W + W_W;
    localparam int PH_W  = HI_W + W_W;
    localparam int SUM_W = IN_W + W_W + 1;
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SHIFT - 1);

    logic [IN_W-1:0]         mult_u;
    logic [IN_W-1:0]         mag;
    logic [PL_W-1:0]         pa_lo_reg;
    logic [PH_W-1:0]         pa_hi_reg;
    logic                    neg_a_reg;
    logic [SIDE_W-1:0]       side_a_reg;
    logic [SUM_W-1:0]        sum_b_next;
    logic [SUM_W-1:0]        sum_b_reg;
    logic                    neg_b_reg;
    logic [SIDE_W-1:0]       side_b_reg;
    logic [OUT_W-1:0]        shr;
    logic signed [OUT_W-1:0] result_next;
    logic signed [OUT_W-1:0] result_reg;
    logic [SIDE_W-1:0]       side_c_reg;

    assign mult_u = $unsigned(mult);
    assign mag    = mult[IN_W-1] ? (~mult_u + IN_W'(1)) : mult_u;

    assign sum_b_next = (SUM_W'(pa_hi_reg) << LO_W) + SUM_W'(pa_lo_reg) + RND;

    assign shr         = OUT_W'(sum_b_reg >> SHIFT);
    assign result_next = neg_b_reg ? (ADDEND - $signed(shr)) : (ADDEND + $signed(shr));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_lo_reg  <= PL_W'(mag[LO_W-1:0]) * PL_W'(w);
            pa_hi_reg  <= PH_W'(mag[IN_W-1:LO_W]) * PH_W'(w);
            neg_a_reg  <= mult[IN_W-1];
            side_a_reg <= side;
            sum_b_reg  <= sum_b_next;
            neg_b_reg  <= neg_a_reg;
            side_b_reg <= side_a_reg;
            result_reg <= result_next;
            side_c_reg <= side_b_reg;
        end
    end

    assign result   = result_reg;
    assign side_out = side_c_reg;

endmodule

`default_nettype wire

@@ rtl/stc_finish.sv @@
`default_nettype none

module stc_finish (
    input  wire logic                                 clk,
    input  wire stc_pkg::ctl_t                        ctl,
    input  wire logic signed [stc_pkg::T3_W-1:0]      t3,
    input  wire stc_pkg::status_t                     status,
    input  wire logic signed [stc_pkg::TEMP_W-1:0]    temp_max,
    input  wire logic signed [stc_pkg::TEMP_W-1:0]    temp_min,
    output logic signed [stc_pkg::TEMP_W-1:0]         temperature_mdeg,
    output logic [stc_pkg::STATUS_W-1:0]              range_status
);

    localparam int T3_W   = stc_pkg::T3_W;
    localparam int T_W    = stc_pkg::T_W;
    localparam int TEMP_W = stc_pkg::TEMP_W;
    localparam logic signed [T3_W:0] HALF_LSB = (T3_W + 1)'(1) << 31;

    logic signed [T3_W:0]       biased;
    logic signed [T_W-1:0]      t_round;
    logic signed [T_W-1:0]      t_next;
    logic signed [T_W-1:0]      t_reg;
    stc_pkg::status_t           st_reg;
    logic signed [T_W-1:0]      max_x;
    logic signed [T_W-1:0]      min_x;
    logic signed [TEMP_W-1:0]   out_t_next;
    stc_pkg::status_t           out_st_next;
    logic signed [TEMP_W-1:0]   out_t_reg;
    stc_pkg::status_t           out_st_reg;
    logic signed [TEMP_W-1:0]   skid_t_reg;
    stc_pkg::status_t           skid_st_reg;

    assign biased  = $signed({t3[T3_W-1], t3}) + HALF_LSB;
    assign t_round = T_W'(biased >>> 32);

    always_comb
    begin
        case (status)
            stc_pkg::ST_COLD_END: t_next = T_W'(stc_pkg::COLD_MDEG);
            stc_pkg::ST_HOT_END:  t_next = T_W'(stc_pkg::HOT_MDEG);
            default:              t_next = t_round;
        endcase
    end

    assign max_x = T_W'(temp_max);
    assign min_x = T_W'(temp_min);

    always_comb
    begin
        if (t_reg > max_x)
        begin
            out_t_next  = temp_max;
            out_st_next = stc_pkg::ST_CLAMPED;
        end
        else if (t_reg < min_x)
        begin
            out_t_next  = temp_min;
            out_st_next = stc_pkg::ST_CLAMPED;
        end
        else
        begin
            out_t_next  = TEMP_W'(t_reg);
            out_st_next = st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            t_reg      <= t_next;
            st_reg     <= status;
            out_t_reg  <= out_t_next;
            out_st_reg <= out_st_next;
        end
        if (ctl.skid_load)
        begin
            skid_t_reg  <= out_t_reg;
            skid_st_reg <= out_st_reg;
        end
    end

    assign temperature_mdeg = ctl.skid_sel ? skid_t_reg : out_t_reg;
    assign range_status     = ctl.skid_sel ? skid_st_reg : out_st_reg;

endmodule

`default_nettype wire

@@ rtl/sensor_code_to_temperature_cubic.sv @@
// Channel  Handshake                Payload
// in       in_valid / in_ready      adc_code
// out      out_valid / out_ready    temperature_mdeg, range_status
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One word per cycle while the skid register is empty.
// The cubic is evaluated by three two-partial-product multiply/round units in Horner order.
// Reset clears valid bits and loads default limits; cfg_ready is always high.
// A stalled output word moves to a skid register, so one more input word
// is taken before in_ready drops; the pipeline then holds until the skid drains.
`default_nettype none

module sensor_code_to_temperature_cubic #(
    parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [stc_pkg::ADC_W-1:0]              adc_code,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [stc_pkg::TEMP_W-1:0]           temperature_mdeg,
    output logic [stc_pkg::STATUS_W-1:0]                range_status,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [stc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int ADC_W    = stc_pkg::ADC_W;
    localparam int W_W      = stc_pkg::W_W;
    localparam int TEMP_W   = stc_pkg::TEMP_W;
    localparam int STATUS_W = stc_pkg::STATUS_W;
    localparam int SIDE_W   = W_W + STATUS_W;
    localparam logic [ADC_W-1:0] CODE_MASK =
        (SAMPLE_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << SAMPLE_BITS) - 1);

    stc_pkg::ctl_t                  ctl;
    logic [ADC_W-1:0]               cold_end_reg;
    logic [ADC_W-1:0]               cold_end_next;
    logic [ADC_W-1:0]               hot_end_reg;
    logic [ADC_W-1:0]               hot_end_next;
    logic signed [TEMP_W-1:0]       temp_max_reg;
    logic signed [TEMP_W-1:0]       temp_max_next;
    logic signed [TEMP_W-1:0]       temp_min_reg;
    logic signed [TEMP_W-1:0]       temp_min_next;

    logic [ADC_W-1:0]               code;
    stc_pkg::status_t               status_next;
    stc_pkg::status_t               status_reg;
    logic [W_W-1:0]                 w_reg;

    logic signed [stc_pkg::T1_W-1:0] t1;
    logic signed [stc_pkg::T2_W-1:0] t2;
    logic signed [stc_pkg::T3_W-1:0] t3;
    logic [SIDE_W-1:0]               side_a;
    logic [SIDE_W-1:0]               side_b;
    logic [STATUS_W-1:0]             side_c;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cold_end_next = cold_end_reg;
        hot_end_next  = hot_end_reg;
        temp_max_next = temp_max_reg;
        temp_min_next = temp_min_reg;
        if (cfg_valid)
        begin
            case (stc_pkg::cfg_index_t'(cfg_index))
                stc_pkg::CFG_COLD_END: cold_end_next = cfg_data[ADC_W-1:0];
                stc_pkg::CFG_HOT_END:  hot_end_next  = cfg_data[ADC_W-1:0];
                stc_pkg::CFG_TEMP_MAX: temp_max_next = $signed(cfg_data[TEMP_W-1:0]);
                stc_pkg::CFG_TEMP_MIN: temp_min_next = $signed(cfg_data[TEMP_W-1:0]);
                default:               cold_end_next = cold_end_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cold_end_reg <= stc_pkg::COLD_END_RST;
            hot_end_reg  <= stc_pkg::HOT_END_RST;
            temp_max_reg <= stc_pkg::TEMP_MAX_RST;
            temp_min_reg <= stc_pkg::TEMP_MIN_RST;
        end
        else
        begin
            cold_end_reg <= cold_end_next;
            hot_end_reg  <= hot_end_next;
            temp_max_reg <= temp_max_next;
            temp_min_reg <= temp_min_next;
        end
    end

    assign code = adc_code & CODE_MASK;

    always_comb
    begin
        if (code > cold_end_reg)
        begin
            status_next = stc_pkg::ST_COLD_END;
        end
        else if (code < hot_end_reg)
        begin
            status_next = stc_pkg::ST_HOT_END;
        end
        else
        begin
            status_next = stc_pkg::ST_IN_RANGE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            w_reg      <= W_W'(code) * W_W'(stc_pkg::MV_SCALE);
            status_reg <= status_next;
        end
    end

    stc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    stc_mulrnd #(
        .IN_W   (stc_pkg::COEF_A_W),
        .OUT_W  (stc_pkg::T1_W),
        .SHIFT  (stc_pkg::SH_A - 32 + SAMPLE_BITS),
        .SIDE_W (SIDE_W),
        .ADDEND (stc_pkg::COEF_B_Q48)
    ) u_mul_a (
        .clk      (clk),
        .adv      (ctl.adv),
        .mult     (stc_pkg::COEF_A_Q56),
        .w        (w_reg),
        .side     ({w_reg, status_reg}),
        .result   (t1),
        .side_out (side_a)
    );

    stc_mulrnd #(
        .IN_W   (stc_pkg::T1_W),
        .OUT_W  (stc_pkg::T2_W),
        .SHIFT  (stc_pkg::SH_B - 32 + SAMPLE_BITS),
        .SIDE_W (SIDE_W),
        .ADDEND (stc_pkg::COEF_C_Q32)
    ) u_mul_b (
        .clk      (clk),
        .adv      (ctl.adv),
        .mult     (t1),
        .w        (side_a[SIDE_W-1:STATUS_W]),
        .side     (side_a),
        .result   (t2),
        .side_out (side_b)
    );

    stc_mulrnd #(
        .IN_W   (stc_pkg::T2_W),
        .OUT_W  (stc_pkg::T3_W),
        .SHIFT  (stc_pkg::SH_C - 32 + SAMPLE_BITS),
        .SIDE_W (STATUS_W),
        .ADDEND (stc_pkg::COEF_D_Q32)
    ) u_mul_c (
        .clk      (clk),
        .adv      (ctl.adv),
        .mult     (t2),
        .w        (side_b[SIDE_W-1:STATUS_W]),
        .side     (side_b[STATUS_W-1:0]),
        .result   (t3),
        .side_out (side_c)
    );

    stc_finish u_finish (
        .clk              (clk),
        .ctl              (ctl),
        .t3               (t3),
        .status           (stc_pkg::status_t'(side_c)),
        .temp_max         (temp_max_reg),
        .temp_min         (temp_min_reg),
        .temperature_mdeg (temperature_mdeg),
        .range_status     (range_status)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_BITS  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_CODES  = 160;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic signed [stc_pkg::TEMP_W-1:0] mdeg;
        stc_pkg::status_t                  status;
    } temp_word_t;

    class temp_scoreboard;
        localparam longint CUBE_Q56   = -64'sd76683691575;
        localparam longint SQUARE_Q48 = -64'sd1621218460235;
        localparam longint LINEAR_Q32 = -64'sd768748894867;
        localparam longint OFFSET_Q32 = 64'sd879854115356672;

        int                                code_bits;
        logic [stc_pkg::ADC_W-1:0]         cold_code;
        logic [stc_pkg::ADC_W-1:0]         hot_code;
        logic signed [stc_pkg::TEMP_W-1:0] max_mdeg;
        logic signed [stc_pkg::TEMP_W-1:0] min_mdeg;
        temp_word_t                        pending_temps[$];
        int                                errors;

        function new(int bits);
            code_bits = bits;
            cold_code = stc_pkg::COLD_END_RST;
            hot_code  = stc_pkg::HOT_END_RST;
            max_mdeg  = stc_pkg::TEMP_MAX_RST;
            min_mdeg  = stc_pkg::TEMP_MIN_RST;
            errors    = 0;
        endfunction

        function void write_reg(stc_pkg::cfg_index_t idx,
                                logic [stc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                stc_pkg::CFG_COLD_END: cold_code = data[stc_pkg::ADC_W-1:0];
                stc_pkg::CFG_HOT_END:  hot_code  = data[stc_pkg::ADC_W-1:0];
                stc_pkg::CFG_TEMP_MAX: max_mdeg  = data;
                stc_pkg::CFG_TEMP_MIN: min_mdeg  = data;
                default: ;
            endcase
        endfunction

        // exact product, shift back, round magnitude half away from zero
        function longint mag_mul_round(longint s, logic [63:0] u, int sh);
            logic [63:0]  mag;
            logic [127:0] prod;
            logic [63:0]  res;
            mag  = (s < 0) ? 64'(-s) : 64'(s);
            prod = {64'b0, mag} * {64'b0, u};
            prod = prod + (128'd1 << (sh - 1));
            res  = 64'(prod >> sh);
            res[63] = 1'b0;
            return (s < 0) ? -longint'(res) : longint'(res);
        endfunction

        function longint cubic_mdeg(logic [stc_pkg::ADC_W-1:0] code);
            logic [63:0] volts_q32;
            logic [63:0] biased;
            longint      t1;
            longint      t2;
            longint      t3;
            volts_q32 = (64'(code) * 64'd3300) << (32 - code_bits);
            t1 = mag_mul_round(CUBE_Q56, volts_q32, 40) + SQUARE_Q48;
            t2 = mag_mul_round(t1, volts_q32, 48) + LINEAR_Q32;
            t3 = mag_mul_round(t2, volts_q32, 32) + OFFSET_Q32;
            biased = 64'(t3) + (64'd1 << 31) + (64'd1 << 56);
            return longint'(biased >> 32) - (longint'(1) <<< 24);
        endfunction

        function void note_code(logic [stc_pkg::ADC_W-1:0] raw);
            logic [stc_pkg::ADC_W-1:0] code;
            longint                    t;
            stc_pkg::status_t          st;
            temp_word_t                w;
            code = raw & stc_pkg::ADC_W'((64'd1 << code_bits) - 1);
            if (code > cold_code) begin
                t  = stc_pkg::COLD_MDEG;
                st = stc_pkg::ST_COLD_END;
            end else if (code < hot_code) begin
                t  = stc_pkg::HOT_MDEG;
                st = stc_pkg::ST_HOT_END;
            end else begin
                t  = cubic_mdeg(code);
                st = stc_pkg::ST_IN_RANGE;
            end
            if (t > longint'(max_mdeg)) begin
                t  = longint'(max_mdeg);
                st = stc_pkg::ST_CLAMPED;
            end else if (t < longint'(min_mdeg)) begin
                t  = longint'(min_mdeg);
                st = stc_pkg::ST_CLAMPED;
            end
            w.mdeg   = stc_pkg::TEMP_W'(t);
            w.status = st;
            pending_temps.push_back(w);
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic signed [stc_pkg::TEMP_W-1:0] mdeg,
                        logic [stc_pkg::STATUS_W-1:0] status);
            temp_word_t w;
            if (pending_temps.size() == 0) begin
                report($sformatf("unexpected word: temperature %0d status %0d", mdeg, status));
                return;
            end
            w = pending_temps.pop_front();
            if (mdeg !== w.mdeg)
                report($sformatf("temperature %0d, expected %0d", mdeg, $signed(w.mdeg)));
            if (status !== w.status)
                report($sformatf("status %0d, expected %0d", status, w.status));
        endtask

        function int pending();
            return pending_temps.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic [stc_pkg::ADC_W-1:0]         adc_code;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [stc_pkg::TEMP_W-1:0] temperature_mdeg;
    logic [stc_pkg::STATUS_W-1:0]      range_status;
    logic                              cfg_valid;
    logic                              cfg_ready;
    stc_pkg::cfg_index_t               cfg_index;
    logic [stc_pkg::CFG_DATA_W-1:0]    cfg_data;

    int             send_idle_pct;
    int             stall_pct;
    int             idle_cycles = 0;
    int             cold_lim;
    int             hot_lim;
    temp_scoreboard sb;

    sensor_code_to_temperature_cubic #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .adc_code         (adc_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .temperature_mdeg (temperature_mdeg),
        .range_status     (range_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_code(adc_code);
            if (out_valid && out_ready)
                sb.check_word(temperature_mdeg, range_status);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[sensor_code_to_temperature_cubic] ERROR");
        $finish;
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 72; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 72; end
            default:       begin send_idle_pct = 6;  stall_pct = 6;  end
        endcase
    endtask

    // valid is left high; the caller drops it after the last word
    task automatic write_reg(stc_pkg::cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= stc_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_limits(int cold, int hot, int max_mdeg, int min_mdeg);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        write_reg(stc_pkg::CFG_COLD_END, cold);
        write_reg(stc_pkg::CFG_HOT_END, hot);
        write_reg(stc_pkg::CFG_TEMP_MAX, max_mdeg);
        write_reg(stc_pkg::CFG_TEMP_MIN, min_mdeg);
        cfg_valid <= 1'b0;
        cold_lim = cold;
        hot_lim  = hot;
    endtask

    task automatic send_code(logic [stc_pkg::ADC_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [stc_pkg::ADC_W-1:0] pick_code();
        int r;
        int c;
        r = $urandom_range(9);
        if (r < 4)
            return stc_pkg::ADC_W'($urandom_range(65535));
        if (r < 8)
            return stc_pkg::ADC_W'($urandom_range(hot_lim, cold_lim));
        c = ((r == 8) ? cold_lim : hot_lim) + int'($urandom_range(4)) - 2;
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        return stc_pkg::ADC_W'(c);
    endfunction

    task automatic run_codes(int n);
        repeat (n) send_code(pick_code());
    endtask

    initial
    begin
        int unsigned base_codes[14] = '{0, 65535, 27310, 27311, 27309, 6013, 6012, 6014,
                                        1, 32768, 16000, 21845, 43690, 65534};
        int hot;
        int cold;
        int lim_a;
        int lim_b;

        sb            = new(SAMPLE_BITS);
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        adc_code      = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = stc_pkg::CFG_COLD_END;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cold_lim      = stc_pkg::COLD_END_RST;
        hot_lim       = stc_pkg::HOT_END_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (base_codes[i])
            send_code(stc_pkg::ADC_W'(base_codes[i]));

        // cold end wins where both thresholds hold
        set_limits(1000, 50000, 150000, -55000);
        send_code(2000);
        send_code(500);
        send_code(60000);

        // forced ends and cubic values clamped
        set_limits(27310, 6013, 20000, 10000);
        send_code(5000);
        send_code(30000);
        send_code(16000);
        send_code(9000);

        // minimum above maximum, whole code range on the cubic
        set_limits(65535, 0, -55000, 150000);
        send_code(0);
        send_code(65535);
        send_code(20000);

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: set_limits(stc_pkg::COLD_END_RST, stc_pkg::HOT_END_RST,
                              stc_pkg::TEMP_MAX_RST, stc_pkg::TEMP_MIN_RST);
                1: set_limits(65535, 0, 150000, -55000);
                2: set_limits(0, 65535, 150000, -55000);
                3: set_limits(27310, 6013, 150000, 150000);
                4: set_limits(27310, 6013, -55000, -55000);
                default: begin
                    hot  = $urandom_range(30000);
                    cold = $urandom_range(65535, hot);
                    if ($urandom_range(4) == 0) begin
                        lim_a = hot;
                        hot   = cold;
                        cold  = lim_a;
                    end
                    lim_a = int'($urandom_range(205000)) - 55000;
                    lim_b = int'($urandom_range(205000)) - 55000;
                    if (lim_a < lim_b && $urandom_range(3) != 0)
                        set_limits(cold, hot, lim_b, lim_a);
                    else
                        set_limits(cold, hot, lim_a, lim_b);
                end
            endcase
            set_idling(idle_mode_t'(p % 4));
            run_codes(PHASE_CODES);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("[sensor_code_to_temperature_cubic] OK");
        else
            $display("[sensor_code_to_temperature_cubic] ERROR");
        $finish;
    end

endmodule
